FILE: hw/rtl/owk_pkg.sv
package owk_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 30;

   // datapath widths
   localparam int XW       = 34;   // cordic x and y, q30
   localparam int ZW       = 33;   // cordic residual angle
   localparam int AW       = 44;   // multiplier a operand
   localparam int BW       = 34;   // multiplier b operand
   localparam int PW       = 78;   // full product
   localparam int LOW_BITS = 22;   // split point of the a operand
   localparam int PPW      = LOW_BITS + 1 + BW;

   localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [22:0]          HALF_ROOT3  = 23'd3632374;

   localparam logic [23:0] INV_RADIUS_RST = 24'd860053;
   localparam logic [23:0] BASE_RATIO_RST = 24'd202113;

   localparam int          CSR_IDX_W      = 2;
   localparam logic [1:0]  CSR_INV_RADIUS = 2'd0;
   localparam logic [1:0]  CSR_BASE_RATIO = 2'd1;

   localparam logic [1:0]  PH_LO = 2'd0;
   localparam logic [1:0]  PH_HI = 2'd1;
   localparam logic [1:0]  PH_WB = 2'd2;

   typedef enum logic [3:0] {
      OP_VX_C  = 4'd0,
      OP_VY_S  = 4'd1,
      OP_VX_S  = 4'd2,
      OP_VY_C  = 4'd3,
      OP_DX_R  = 4'd4,
      OP_DY_R  = 4'd5,
      OP_ROT   = 4'd6,
      OP_KDX   = 4'd7,
      OP_SPEED = 4'd8,
      OP_ANG0  = 4'd9,
      OP_ANG1  = 4'd10,
      OP_ANG2  = 4'd11
   } op_type;

   typedef struct packed {
      logic       load;
      logic       cordic_step;
      logic [4:0] step_idx;
      logic       math_en;
      op_type     op;
      logic [1:0] phase;
      logic       out_load;
   } dp_cmd_type;

   function automatic logic [29:0] atan_entry(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0:  r = 30'd536870912;
         5'd1:  r = 30'd316933406;
         5'd2:  r = 30'd167458907;
         5'd3:  r = 30'd85004756;
         5'd4:  r = 30'd42667331;
         5'd5:  r = 30'd21354465;
         5'd6:  r = 30'd10679838;
         5'd7:  r = 30'd5340245;
         5'd8:  r = 30'd2670163;
         5'd9:  r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         5'd24: r = 30'd41;
         5'd25: r = 30'd20;
         5'd26: r = 30'd10;
         5'd27: r = 30'd5;
         5'd28: r = 30'd3;
         5'd29: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/owk_ctrl.sv
module owk_ctrl
   import owk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tuser,
   output logic       req_tready,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CORDIC = 4'b0010,
      ST_MATH   = 4'b0100,
      ST_OUT    = 4'b1000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic [4:0]    step_ff, step_in;
   op_type        op_ff, op_in;
   logic [1:0]    phase_ff, phase_in;
   logic          valid_ff, valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      op_in           = op_ff;
      phase_in        = phase_ff;
      cmd             = '0;
      cmd.step_idx    = step_ff;
      cmd.op          = op_ff;
      cmd.phase       = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid && !req_tuser) begin
               state_in = ST_CORDIC;
               step_in  = 5'd0;
            end
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (step_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = ST_MATH;
               op_in    = OP_VX_C;
               phase_in = PH_LO;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_MATH: begin
            cmd.math_en = 1'b1;
            if (phase_ff == PH_WB) begin
               phase_in = PH_LO;
               if (op_ff == OP_ANG2) begin
                  state_in = ST_OUT;
               end else begin
                  op_in = op_type'(op_ff + 4'd1);
               end
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         ST_OUT: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign valid_in = cmd.out_load | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 5'd0;
         op_ff    <= OP_VX_C;
         phase_ff <= PH_LO;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         op_ff    <= op_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: hw/rtl/owk_dpath.sv
module owk_dpath
   import owk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dp_cmd_type   cmd,
   input  logic         req_tuser,
   input  logic [287:0] req_tdata,
   input  logic [23:0]  inv_radius,
   input  logic [23:0]  base_ratio,
   output logic [239:0] rsp_tdata
);

   localparam logic signed [ZW-1:0] QUARTER = 33'sd1073741824;
   localparam logic signed [ZW-1:0] HALF    = 33'sd2147483648;

   // motion state
   logic [31:0]        prior_ff;
   logic               known_ff;
   logic signed [47:0] angle_ff [3];
   logic [31:0]        dt_ff;
   logic signed [31:0] vx_ff, vy_ff, yaw_ff;

   // cordic
   logic signed [XW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;

   // arithmetic
   logic signed [PW-1:0] p_ff, t_ff;
   logic signed [AW-1:0] dx_ff, dy_ff, rot_ff;
   logic signed [31:0]   spd_ff [3];
   logic [239:0]         out_ff;

   // input fields
   logic [31:0]        f_time;
   logic [15:0]        f_heading;
   logic [ANGLE_BITS-1:0] hneg;
   logic signed [ZW-1:0]  z0, z_init;
   logic signed [XW-1:0]  x_init;

   assign f_time    = req_tdata[31:0];
   assign f_heading = req_tdata[47:32];
   assign hneg      = ANGLE_BITS'(0) - f_heading[ANGLE_BITS-1:0];
   assign z0        = ZW'($signed({hneg, {(32 - ANGLE_BITS){1'b0}}}));

   always_comb begin
      z_init = z0;
      x_init = CORDIC_GAIN;
      if (z0 > QUARTER) begin
         z_init = z0 - HALF;
         x_init = -CORDIC_GAIN;
      end else if (z0 < -QUARTER) begin
         z_init = z0 + HALF;
         x_init = -CORDIC_GAIN;
      end
   end

   logic signed [XW-1:0] xs, ys;
   logic signed [ZW-1:0] at;
   assign xs = x_ff >>> cmd.step_idx;
   assign ys = y_ff >>> cmd.step_idx;
   assign at = ZW'($signed({1'b0, atan_entry(cmd.step_idx)}));

   // shared multiplier, a operand split in a low and a high part
   logic signed [AW-1:0]  a_op;
   logic signed [BW-1:0]  b_op;
   logic signed [LOW_BITS:0] a_part;
   logic signed [PPW-1:0] pp;
   logic signed [PW-1:0]  pp_ext, p_in;
   logic [1:0]            ang_sel;

   always_comb begin
      a_op    = '0;
      b_op    = '0;
      ang_sel = 2'd0;
      case (cmd.op)
         OP_VX_C: begin a_op = AW'(vx_ff); b_op = x_ff; end
         OP_VY_S: begin a_op = AW'(vy_ff); b_op = y_ff; end
         OP_VX_S: begin a_op = AW'(vx_ff); b_op = y_ff; end
         OP_VY_C: begin a_op = AW'(vy_ff); b_op = x_ff; end
         OP_DX_R: begin a_op = dx_ff; b_op = BW'($signed({1'b0, inv_radius})); end
         OP_DY_R: begin a_op = dy_ff; b_op = BW'($signed({1'b0, inv_radius})); end
         OP_ROT:  begin
            a_op = -AW'(yaw_ff);
            b_op = BW'($signed({1'b0, base_ratio}));
         end
         OP_KDX:  begin a_op = dx_ff; b_op = BW'($signed({1'b0, HALF_ROOT3})); end
         OP_ANG0: begin a_op = AW'(spd_ff[0]); b_op = BW'($signed({1'b0, dt_ff}));
                        ang_sel = 2'd0; end
         OP_ANG1: begin a_op = AW'(spd_ff[1]); b_op = BW'($signed({1'b0, dt_ff}));
                        ang_sel = 2'd1; end
         OP_ANG2: begin a_op = AW'(spd_ff[2]); b_op = BW'($signed({1'b0, dt_ff}));
                        ang_sel = 2'd2; end
         default: begin a_op = '0; b_op = '0; end
      endcase
   end

   // high part carries the sign, low part is unsigned
   assign a_part = (cmd.phase == PH_HI) ? (LOW_BITS + 1)'($signed(a_op[AW-1:LOW_BITS]))
                                        : $signed({1'b0, a_op[LOW_BITS-1:0]});
   assign pp     = a_part * b_op;
   assign pp_ext = PW'(pp);
   assign p_in   = (cmd.phase == PH_HI) ? p_ff + (pp_ext <<< LOW_BITS) : pp_ext;

   function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                input int s);
      logic signed [PW-1:0] half;
      half = PW'(1) <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647)       r = 32'sh7fffffff;
      else if (v < -48'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   // speed forming
   logic signed [47:0] rot_w, dy_w, hdy_w, kdx_w;
   assign rot_w = 48'(rot_ff);
   assign dy_w  = 48'(dy_ff);
   assign hdy_w = (dy_w + 48'sd1) >>> 1;
   assign kdx_w = t_ff[47:0];

   // angle integration
   logic signed [PW-1:0] step_full;
   logic signed [48:0]   ang_sum;
   logic signed [47:0]   ang_sat;
   assign step_full = rnd(p_ff, FRAC_BITS);
   assign ang_sum   = 49'(angle_ff[ang_sel]) + step_full[48:0];
   always_comb begin
      if (ang_sum > 49'sh0_7fff_ffff_ffff)       ang_sat = 48'sh7fff_ffff_ffff;
      else if (ang_sum < -49'sh0_8000_0000_0000) ang_sat = 48'sh8000_0000_0000;
      else                                       ang_sat = ang_sum[47:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff <= '0;
         known_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            angle_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         if (req_tuser) begin
            angle_ff[0] <= req_tdata[191:144];
            angle_ff[1] <= req_tdata[239:192];
            angle_ff[2] <= req_tdata[287:240];
            known_ff    <= 1'b0;
         end else begin
            prior_ff <= f_time;
            known_ff <= 1'b1;
         end
      end else if (cmd.math_en && cmd.phase == PH_WB &&
                   (cmd.op == OP_ANG0 || cmd.op == OP_ANG1 || cmd.op == OP_ANG2)) begin
         angle_ff[ang_sel] <= ang_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !req_tuser) begin
         dt_ff  <= known_ff ? f_time - prior_ff : 32'd0;
         vx_ff  <= req_tdata[79:48];
         vy_ff  <= req_tdata[111:80];
         yaw_ff <= req_tdata[143:112];
         x_ff   <= x_init;
         y_ff   <= '0;
         z_ff   <= z_init;
      end
      if (cmd.cordic_step) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
      end
      if (cmd.math_en) begin
         if (cmd.phase != PH_WB) begin
            p_ff <= p_in;
         end else begin
            case (cmd.op)
               OP_VX_C:  t_ff   <= p_ff;
               OP_VY_S:  dx_ff  <= AW'(rnd(t_ff - p_ff, 30));
               OP_VX_S:  t_ff   <= p_ff;
               OP_VY_C:  dy_ff  <= AW'(rnd(t_ff + p_ff, 30));
               OP_DX_R:  dx_ff  <= AW'(rnd(p_ff, FRAC_BITS));
               OP_DY_R:  dy_ff  <= AW'(rnd(p_ff, FRAC_BITS));
               OP_ROT:   rot_ff <= AW'(rnd(p_ff, FRAC_BITS));
               OP_KDX:   t_ff   <= rnd(p_ff, 22);
               OP_SPEED: begin
                  spd_ff[0] <= sat32(rot_w - hdy_w - kdx_w);
                  spd_ff[1] <= sat32(rot_w - hdy_w + kdx_w);
                  spd_ff[2] <= sat32(rot_w + dy_w);
               end
               default: ;
            endcase
         end
      end
      if (cmd.out_load) begin
         out_ff <= {angle_ff[2], angle_ff[1], angle_ff[0],
                    spd_ff[2], spd_ff[1], spd_ff[0]};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

FILE: hw/rtl/omni_base_wheel_kinematics.sv
// inverse kinematics and wheel position integrator for a three-wheel omni
// base with wheels 120 degrees apart. an update word (tuser 0) carries a
// timestamp, heading, body velocity and yaw rate; the block rotates the
// velocity by minus the heading with a 30-step cordic, scales by the inverse
// wheel radius, forms the three wheel speeds and integrates each wheel angle
// by speed times elapsed time (zero on the first tick after reset or
// restart), returning one result word. a restart word (tuser 1) loads the
// wheel angles from feedback and returns nothing. an update holds the input
// off through the accepting cycle, 30 cordic iterations, 12 multiply steps
// on one shared 23 x 34 bit multiplier and the hand-over of the result,
// which waits while an earlier result is not yet taken. a finished result
// waits in the output register while the next word is accepted.
module omni_base_wheel_kinematics
   import owk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // req_tdata, lowest bit up: time_now, heading, vel_x, vel_y, yaw_rate,
   // feedback_pos_0, feedback_pos_1, feedback_pos_2
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [287:0]         req_tdata,
   input  logic                 req_tuser,   // func
   // rsp_tdata, lowest bit up: wheel_speed_0..2, wheel_angle_0..2
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [239:0]         rsp_tdata,
   // configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]          csr_wdata
);

   logic [23:0] inv_radius_ff;
   logic [23:0] base_ratio_ff;
   dp_cmd_type  cmd;

   // configuration registers, indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_radius_ff <= INV_RADIUS_RST;
         base_ratio_ff <= BASE_RATIO_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INV_RADIUS: inv_radius_ff <= csr_wdata;
            CSR_BASE_RATIO: base_ratio_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: cordic iterations, multiply steps, result hand-over
   owk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   // cordic, shared multiplier, wheel state and output register
   owk_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .inv_radius (inv_radius_ff),
      .base_ratio (base_ratio_ff),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTH
   // a restart word never produces a result
   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result appeared after a restart word");

   // an update word occupies the sequencer
   a_update_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser) |=> !req_tready)
      else $error("input still ready after an update word");

   // a new result is only handed over from the output stage
   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result valid rose while sequencer was idle");
`endif

endmodule
